// ===== sv/alps_pkg.sv =====
// Package for the ALPN protocol selector.
// Holds list limits, register indexes, status codes and the token byte lookup.
// No dependencies.
package alps_pkg;

   localparam int LIST_MAX    = 65535;
   localparam int TOKEN_BYTES = 16;

   localparam logic [15:0] LIST_LIMIT = 16'(LIST_MAX);
   localparam logic [5:0]  TOKEN_CAP  = 6'(TOKEN_BYTES);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREF_LEN      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREF_TOKEN_LO = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREF_TOKEN_HI = 2'd2;

   localparam logic [4:0]  PREF_LEN_RESET = 5'd2;
   localparam logic [63:0] PREF_LO_RESET  = 64'h3333;
   localparam logic [63:0] PREF_HI_RESET  = 64'h0;

   localparam logic [1:0] STATUS_MATCH = 2'd0;
   localparam logic [1:0] STATUS_FIRST = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] sel_offset;
      logic [7:0]  sel_len;
   } rsp_beat_type;

   // token bytes past the 16 held in the registers read as zero
   function automatic logic [7:0] token_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [4:0] idx);
      logic [15:0][7:0] tok;
      tok = {hi, lo};
      if (idx[4]) begin
         return 8'd0;
      end
      return tok[idx[3:0]];
   endfunction

   function automatic logic [4:0] eff_len(input logic [4:0] pref_len);
      logic [5:0] ext;
      ext = {1'b0, pref_len};
      if (ext > TOKEN_CAP) begin
         return TOKEN_CAP[4:0];
      end
      return pref_len;
   endfunction

endpackage

// ===== sv/alps_if.sv =====
// Handshake channels of the ALPN protocol selector: request and response.
// Depends on nothing; payload widths fixed by the list and result formats.
interface alps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] list_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output list_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input list_byte, input has_byte, input last,
                   output ready);
endinterface

interface alps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] sel_offset;
   logic [7:0]  sel_len;

   modport source (output valid, output status, output sel_offset, output sel_len,
                   input ready);
   modport sink   (input valid, input status, input sel_offset, input sel_len,
                   output ready);
endinterface

// ===== sv/alpn_protocol_select_top.sv =====
// Top level of the ALPN protocol selector: list scan state, token compare, result buffer.
// Depends on alps_pkg and the channel interfaces in alps_if.sv.
//
//   channel    dir   beat                               when
//   req_chan   in    list_byte, has_byte, last          valid & ready
//   rsp_chan   out   status, sel_offset, sel_len        valid & ready, one per last beat
//   csr_*      in    csr_index, csr_wdata               csr_we
//
// One beat per cycle while req_chan.ready is high; scan state updates at the
// accept edge, and the result is registered at the edge that accepts the last
// beat. A two-entry output buffer (result register plus skid) lets req_chan keep
// flowing; req_chan.ready drops only while both entries hold unread results.
// Synchronous reset clears scan state, buffer and restores the register defaults.
module alpn_protocol_select_top
   import alps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   alps_req_if.sink               req_chan,
   alps_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [4:0]   pref_len_ff;
   logic [63:0]  pref_lo_ff;
   logic [63:0]  pref_hi_ff;

   logic [15:0]  byte_pos_ff,     byte_pos_in;
   logic [7:0]   bytes_left_ff,   bytes_left_in;
   logic [15:0]  cand_start_ff,   cand_start_in;
   logic         cand_ok_ff,      cand_ok_in;
   logic [4:0]   cand_index_ff,   cand_index_in;
   logic         found_ff,        found_in;
   logic [15:0]  found_offset_ff, found_offset_in;
   logic [7:0]   first_len_ff,    first_len_in;

   logic         out_valid_ff,  out_valid_in;
   rsp_beat_type out_data_ff,   out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type skid_data_ff,  skid_data_in;

   logic         accept;
   logic         push;
   logic         pop;
   logic [4:0]   elen;
   logic [7:0]   b;
   logic         take;
   logic         cand_ok_mid;
   logic [7:0]   left_dec;
   rsp_beat_type result;

   assign accept = req_chan.valid && req_chan.ready;
   assign push   = accept && req_chan.last;
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign elen   = eff_len(pref_len_ff);
   assign b      = req_chan.list_byte;
   assign take   = req_chan.has_byte && (byte_pos_ff < LIST_LIMIT);

   assign req_chan.ready      = !skid_valid_ff;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_data_ff.status;
   assign rsp_chan.sel_offset = out_data_ff.sel_offset;
   assign rsp_chan.sel_len    = out_data_ff.sel_len;

   // scan step for one list byte
   always_comb begin
      byte_pos_in     = byte_pos_ff;
      bytes_left_in   = bytes_left_ff;
      cand_start_in   = cand_start_ff;
      cand_ok_in      = cand_ok_ff;
      cand_index_in   = cand_index_ff;
      found_in        = found_ff;
      found_offset_in = found_offset_ff;
      first_len_in    = first_len_ff;
      cand_ok_mid     = cand_ok_ff;
      left_dec        = bytes_left_ff - 8'd1;
      if (take) begin
         byte_pos_in = byte_pos_ff + 16'd1;
         if (bytes_left_ff == 8'd0) begin
            if (byte_pos_ff == 16'd0) begin
               first_len_in = b;
            end
            cand_start_in = byte_pos_ff;
            bytes_left_in = b;
            cand_ok_in    = (b == {3'd0, elen});
            cand_index_in = 5'd0;
            if ((b == 8'd0) && (b == {3'd0, elen}) && !found_ff) begin
               found_in        = 1'b1;
               found_offset_in = byte_pos_ff + 16'd1;
            end
         end else begin
            if (cand_ok_ff) begin
               cand_ok_mid   = (b == token_byte(pref_lo_ff, pref_hi_ff, cand_index_ff));
               cand_index_in = cand_index_ff + 5'd1;
            end
            cand_ok_in    = cand_ok_mid;
            bytes_left_in = left_dec;
            if ((left_dec == 8'd0) && cand_ok_mid && !found_ff) begin
               found_in        = 1'b1;
               found_offset_in = cand_start_ff + 16'd1;
            end
         end
      end
   end

   always_comb begin
      if (found_in) begin
         result.status     = STATUS_MATCH;
         result.sel_offset = found_offset_in;
         result.sel_len    = {3'd0, elen};
      end else if ((byte_pos_in != 16'd0) && (first_len_in != 8'd0)) begin
         result.status     = STATUS_FIRST;
         result.sel_offset = 16'd1;
         result.sel_len    = first_len_in;
      end else begin
         result.status     = STATUS_NONE;
         result.sel_offset = 16'd0;
         result.sel_len    = 8'd0;
      end
   end

   // result register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pref_len_ff <= PREF_LEN_RESET;
         pref_lo_ff  <= PREF_LO_RESET;
         pref_hi_ff  <= PREF_HI_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PREF_LEN:      pref_len_ff <= csr_wdata[4:0];
            CSR_PREF_TOKEN_LO: pref_lo_ff  <= csr_wdata;
            CSR_PREF_TOKEN_HI: pref_hi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         byte_pos_ff     <= 16'd0;
         bytes_left_ff   <= 8'd0;
         cand_start_ff   <= 16'd0;
         cand_ok_ff      <= 1'b0;
         cand_index_ff   <= 5'd0;
         found_ff        <= 1'b0;
         found_offset_ff <= 16'd0;
         first_len_ff    <= 8'd0;
      end else if (accept) begin
         byte_pos_ff     <= byte_pos_in;
         bytes_left_ff   <= bytes_left_in;
         cand_start_ff   <= cand_start_in;
         cand_ok_ff      <= cand_ok_in;
         cand_index_ff   <= cand_index_in;
         found_ff        <= found_in;
         found_offset_ff <= found_offset_in;
         first_len_ff    <= first_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
